FILE: hw/rtl/samdu_pkg.sv
// Shared types and constants for the shift-add multiply / shift-subtract divide unit.
// Used by samdu_cell, samdu_ctrl and shift_add_multiply_divide_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package samdu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // Input item: action, operand_a, operand_b packed from bit 0 up.
  localparam int IN_ACT_LSB  = 0;
  localparam int IN_A_LSB    = 1;
  localparam int IN_B_LSB    = 1 + DATA_WIDTH;
  localparam int IN_BITS     = 1 + 2 * DATA_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Result item: result, divide_by_zero packed from bit 0 up.
  localparam int OUT_DZ_LSB  = DATA_WIDTH;
  localparam int OUT_BITS    = DATA_WIDTH + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic ACT_MUL = 1'b0;
  localparam logic ACT_DIV = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic load;
    logic step;
    logic div_mode;
    logic finish;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/samdu_cell.sv
// One bit slice of the shift-add / shift-subtract datapath.
// Holds one bit each of the accumulator, the shifted operand and the multiplier/quotient.
// Depends on samdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module samdu_cell (
  input  wire logic                  clk,
  input  wire samdu_pkg::cell_ctrl_t ctrl,
  input  wire logic                  ld_x,
  input  wire logic                  ld_y,
  input  wire logic                  p_shift_in,
  input  wire logic                  x_shift_in,
  input  wire logic                  y_from_low,
  input  wire logic                  y_from_high,
  input  wire logic                  y0,
  input  wire logic                  commit,
  input  wire logic                  carry_in,
  output logic                       carry_out,
  output logic                       p,
  output logic                       x,
  output logic                       y
);
  import samdu_pkg::*;

  logic p_r, p_nxt;
  logic x_r, x_nxt;
  logic y_r, y_nxt;
  logic a_in, b_in, sum;

  // Multiply adds x when the current multiplier bit is set; divide subtracts x
  // from the left-shifted remainder (the row's carry-in is one for the subtract).
  always_comb begin
    a_in      = ctrl.div_mode ? p_shift_in : p_r;
    b_in      = ctrl.div_mode ? ~x_r : (x_r & y0);
    sum       = a_in ^ b_in ^ carry_in;
    carry_out = (a_in & b_in) | (carry_in & (a_in ^ b_in));
  end

  always_comb begin
    p_nxt = p_r;
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctrl.load) begin
      p_nxt = 1'b0;
      x_nxt = ld_x;
      y_nxt = ld_y;
    end else if (ctrl.step) begin
      p_nxt = commit ? sum : a_in;
      if (!ctrl.div_mode) begin
        x_nxt = x_shift_in;
        y_nxt = y_from_high;
      end else begin
        y_nxt = y_from_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign p = p_r;
  assign x = x_r;
  assign y = y_r;

endmodule

`default_nettype wire

FILE: hw/rtl/samdu_ctrl.sv
// Sequencer for the cell row: accepts an item, runs one step per bit, hands off the result.
// Depends on samdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module samdu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_action,
  input  wire logic           out_free,
  output logic                in_ready,
  output samdu_pkg::cell_ctrl_t ctrl
);
  import samdu_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             div_r, div_nxt;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_RUN;
      S_RUN:   if (cnt_r == CNT_W'(DATA_WIDTH - 1)) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl.load     = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.finish   = 1'b0;
    ctrl.div_mode = div_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      S_RUN:   ctrl.step   = 1'b1;
      S_DONE:  ctrl.finish = out_free;
      default: in_ready    = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    div_nxt = div_r;
    if (in_fire) begin
      cnt_nxt = '0;
      div_nxt = (in_action == ACT_DIV);
    end else if (ctrl.step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      div_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      div_r   <= div_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/shift_add_multiply_divide_unit.sv
// Top level of the shift-add multiplier / shift-subtract divider.
// Instantiates samdu_ctrl and one samdu_cell per data bit; depends on samdu_pkg.
//
// Usage:
//   The in_ channel takes one item: an action (0 multiply, 1 divide) and two
//   unsigned 32-bit operands. The out_ channel returns one item per input:
//   the low 32 bits of the product or the unsigned quotient, plus a
//   divide-by-zero flag (a zero divisor gives result 0 with the flag set).
//   The datapath is a row of 32 bit cells; each cycle every cell hands its
//   operand and quotient bits to a neighbor while the carry/borrow ripples
//   across the row, resolving one multiplier or quotient bit per cycle.
//   After the input is accepted the row runs 32 steps, then a finish cycle
//   loads the output register. A new item is accepted the cycle after the
//   result is loaded into the output register, so the unit takes no new
//   item while an earlier one is still in progress.
//   The result waits in the output register while out_tready is low; the
//   row holds its finished value and in_tready stays low until the output
//   register is free. Synchronous active-low reset returns the sequencer to
//   idle and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module shift_add_multiply_divide_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: action[0], operand_a[32:1], operand_b[64:33], zero fill.
  input  wire logic [samdu_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // Fields from bit 0: result[31:0], divide_by_zero[32], zero fill.
  output logic [samdu_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import samdu_pkg::*;

  cell_ctrl_t            ctl;
  logic                  in_action;
  logic [DATA_WIDTH-1:0] in_a, in_b;
  logic [DATA_WIDTH-1:0] ld_x, ld_y;
  logic [DATA_WIDTH-1:0] p_w, x_w, y_w;
  logic [DATA_WIDTH:0]   carry_w;
  logic                  commit;
  logic                  out_free;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_result_r, out_result_nxt;
  logic                  out_dz_r, out_dz_nxt;
  logic                  dz_r, dz_nxt;

  assign in_action = in_tdata[IN_ACT_LSB];
  assign in_a      = in_tdata[IN_A_LSB +: DATA_WIDTH];
  assign in_b      = in_tdata[IN_B_LSB +: DATA_WIDTH];

  // Divide keeps the divisor fixed and shifts the dividend through y;
  // multiply shifts the multiplicand left through x and the multiplier right through y.
  assign ld_x = (in_action == ACT_DIV) ? in_b : in_a;
  assign ld_y = (in_action == ACT_DIV) ? in_a : in_b;

  assign out_free = !out_valid_r || out_tready;

  samdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_action),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .ctrl      (ctl)
  );

  // The shifted remainder is one bit wider than the row; its top bit set
  // means the subtract always fits.
  assign carry_w[0] = ctl.div_mode;
  assign commit     = !ctl.div_mode || p_w[DATA_WIDTH-1] || carry_w[DATA_WIDTH];

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    logic p_in, x_in, y_lo, y_hi;
    if (i == 0) begin : g_first
      assign p_in = y_w[DATA_WIDTH-1];
      assign x_in = 1'b0;
      assign y_lo = commit;
    end else begin : g_inner
      assign p_in = p_w[i-1];
      assign x_in = x_w[i-1];
      assign y_lo = y_w[i-1];
    end
    if (i == DATA_WIDTH - 1) begin : g_last
      assign y_hi = 1'b0;
    end else begin : g_lower
      assign y_hi = y_w[i+1];
    end

    samdu_cell u_cell (
      .clk         (clk),
      .ctrl        (ctl),
      .ld_x        (ld_x[i]),
      .ld_y        (ld_y[i]),
      .p_shift_in  (p_in),
      .x_shift_in  (x_in),
      .y_from_low  (y_lo),
      .y_from_high (y_hi),
      .y0          (y_w[0]),
      .commit      (commit),
      .carry_in    (carry_w[i]),
      .carry_out   (carry_w[i+1]),
      .p           (p_w[i]),
      .x           (x_w[i]),
      .y           (y_w[i])
    );
  end

  always_comb begin
    dz_nxt         = dz_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_dz_nxt     = out_dz_r;
    if (ctl.load) begin
      dz_nxt = (in_action == ACT_DIV) && (in_b == '0);
    end
    if (ctl.finish) begin
      out_valid_nxt  = 1'b1;
      out_dz_nxt     = dz_r;
      out_result_nxt = dz_r ? '0 : (ctl.div_mode ? y_w : p_w);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_result_r <= out_result_nxt;
    out_dz_r     <= out_dz_nxt;
    dz_r         <= dz_nxt;
  end

  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata                          = '0;
    out_tdata[DATA_WIDTH-1:0]          = out_result_r;
    out_tdata[OUT_DZ_LSB]              = out_dz_r;
  end

  // Once an item is taken the unit is busy until its result is handed off.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a previous item is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> (!out_valid_r || out_tready))
    else $error("result loaded over an output item not yet taken");

  a_no_step_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ctl.step)
    else $error("row stepping while input side is ready");

  a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DZ_LSB] |-> (out_tdata[DATA_WIDTH-1:0] == '0))
    else $error("divide by zero flagged with a nonzero result");

endmodule

`default_nettype wire
